// ===== rtl/rs485_frame_receiver_assert.svh =====
// Assertion macros for the RS485 frame receiver.
// Needs clk and rst in the including module; compiled out when SYNTH is defined.
`ifndef RS485_FRAME_RECEIVER_ASSERT_SVH
`define RS485_FRAME_RECEIVER_ASSERT_SVH

`ifndef SYNTH

// Same-cycle implication, checked outside reset
`define RFR_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define RFR_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define RFR_ASSERT_IMP(name, ante, cons, msg)
`define RFR_ASSERT_NXT(name, ante, cons, msg)

`endif

`endif

// ===== rtl/rfr_pkg.sv =====
// Shared types and constants of the RS485 frame receiver.
// No dependencies; used by rfr_ctrl, rfr_datapath and the top level.
package rfr_pkg;

  // Frame control characters
  localparam logic [7:0] CH_SOH = 8'h01;
  localparam logic [7:0] CH_STX = 8'h02;
  localparam logic [7:0] CH_ETX = 8'h03;
  localparam logic [7:0] CH_EOT = 8'h04;

  // Result status codes
  localparam logic [2:0] ST_DATA     = 3'd0;
  localparam logic [2:0] ST_CHECKSUM = 3'd1;
  localparam logic [2:0] ST_NO_ETX   = 3'd2;
  localparam logic [2:0] ST_NO_EOT   = 3'd3;
  localparam logic [2:0] ST_TIMEOUT  = 3'd4;

  // Configuration register indexes
  localparam int unsigned CFG_IW = 2;
  localparam int unsigned CFG_DW = 16;
  localparam logic [CFG_IW-1:0] REG_GATEWAY   = 2'd0;
  localparam logic [CFG_IW-1:0] REG_BROADCAST = 2'd1;
  localparam logic [CFG_IW-1:0] REG_COMMAND   = 2'd2;
  localparam logic [CFG_IW-1:0] REG_TIMEOUT   = 2'd3;

  // Message store
  localparam int unsigned STORE_DEPTH = 32;
  localparam int unsigned STORE_AW    = 5;

  typedef struct packed {
    logic       kind;      // 0 byte, 1 millisecond tick
    logic [7:0] rx_byte;
  } rfr_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] destination;
    logic [7:0] source;
    logic [4:0] length;
    logic [4:0] index;
    logic [7:0] payload_byte;
    logic       last;
  } rfr_result_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic       shift_window;
    logic       load_header;
    logic       store_byte;
    logic       take_sum;
    logic       clear_idle;
    logic       tick_idle;
    logic       clear_pos;
    logic       emit_status;
    logic [2:0] status_code;
    logic       run_start;
    logic       run_load;
  } rfr_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic is_tick;
    logic hdr_ok;
    logic hdr_len_zero;
    logic pos_done;
    logic byte_etx;
    logic byte_eot;
    logic sum_ok;
    logic cmd_ok;
    logic len_zero;
    logic timeout_hit;
    logic run_last;
    logic out_free;
  } rfr_stat_t;

endpackage

// ===== rtl/rs485_frame_receiver.sv =====
// Top level of the RS485 frame receiver: joins controller and datapath.
// Depends on rfr_pkg, rfr_ctrl and rfr_datapath.
//
//  channel | handshake                  | payload
//  --------+----------------------------+-----------------------------------
//  item    | item_valid / item_ready    | rfr_item_t: kind, rx_byte
//  result  | result_valid / result_ready| rfr_result_t: status .. last
//  config  | cfg_write (no wait)        | cfg_index, cfg_data
//
// An item is taken whenever the receiver hunts or sits inside a frame.
// A delivered frame streams out byte by byte through the registered read port
// of the 32-entry message store, reading in S_READ and loading in S_LOAD; no item
// is taken until the last byte of the run has been loaded into the output register.
// A status result that meets a stalled output register waits in a pending state and
// blocks items until the transfer slot frees up. Reset clears control state; no store clearing.
module rs485_frame_receiver #(
  parameter int unsigned MAX_BYTES = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  output logic                         item_ready,
  input  rfr_pkg::rfr_item_t           item,
  output logic                         result_valid,
  input  logic                         result_ready,
  output rfr_pkg::rfr_result_t         result,
  input  logic                         cfg_write,
  input  logic [rfr_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [rfr_pkg::CFG_DW-1:0]   cfg_data
);

  // Command and status buses between the two halves
  rfr_pkg::rfr_cmd_t  cmd;
  rfr_pkg::rfr_stat_t st;

  // Controller: frame phase, pending status and data-run sequencing
  rfr_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .st         (st),
    .cmd        (cmd)
  );

  // Datapath: window, checksum, timeout counter, store, output register
  rfr_datapath #(
    .MAX_BYTES (MAX_BYTES)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item         (item),
    .cmd          (cmd),
    .st           (st),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

// ===== rtl/rfr_ctrl.sv =====
// Controller of the RS485 frame receiver: frame phase and result sequencing.
// Depends on rfr_pkg and rs485_frame_receiver_assert.svh.
`include "rs485_frame_receiver_assert.svh"

module rfr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  rfr_pkg::rfr_stat_t st,
  output rfr_pkg::rfr_cmd_t  cmd
);

  localparam logic [2:0] S_HUNT   = 3'd0;
  localparam logic [2:0] S_DATA   = 3'd1;
  localparam logic [2:0] S_ETX    = 3'd2;
  localparam logic [2:0] S_SUM    = 3'd3;
  localparam logic [2:0] S_EOT    = 3'd4;
  localparam logic [2:0] S_STATUS = 3'd5;
  localparam logic [2:0] S_READ   = 3'd6;
  localparam logic [2:0] S_LOAD   = 3'd7;

  logic [2:0] state, state_next;
  logic [2:0] pend, pend_next;
  logic       accept;
  logic       emit_req;
  logic [2:0] code;

  assign item_ready = (state <= S_EOT);
  assign accept     = item_valid && item_ready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    pend_next  = pend;
    emit_req   = 1'b0;
    code       = pend;
    case (state)
      S_HUNT: begin
        if (accept && !st.is_tick) begin
          cmd.shift_window = 1'b1;
          cmd.clear_idle   = 1'b1;
          if (st.hdr_ok) begin
            cmd.load_header = 1'b1;
            state_next      = st.hdr_len_zero ? S_ETX : S_DATA;
          end
        end
      end
      S_DATA, S_ETX, S_SUM, S_EOT: begin
        if (accept && st.is_tick) begin
          cmd.tick_idle = 1'b1;
          if (st.timeout_hit) begin
            emit_req = 1'b1;
            code     = rfr_pkg::ST_TIMEOUT;
          end
        end else if (accept) begin
          cmd.clear_idle = 1'b1;
          case (state)
            S_DATA: begin
              cmd.store_byte = 1'b1;
              if (st.pos_done) begin
                state_next = S_ETX;
              end
            end
            S_ETX: begin
              if (st.byte_etx) begin
                state_next = S_SUM;
              end else begin
                emit_req = 1'b1;
                code     = rfr_pkg::ST_NO_ETX;
              end
            end
            S_SUM: begin
              cmd.take_sum = 1'b1;
              state_next   = S_EOT;
            end
            default: begin
              cmd.clear_pos = 1'b1;
              state_next    = S_HUNT;
              if (!st.byte_eot) begin
                emit_req = 1'b1;
                code     = rfr_pkg::ST_NO_EOT;
              end else if (!st.sum_ok) begin
                emit_req = 1'b1;
                code     = rfr_pkg::ST_CHECKSUM;
              end else if (st.cmd_ok && st.len_zero) begin
                emit_req = 1'b1;
                code     = rfr_pkg::ST_DATA;
              end else if (st.cmd_ok) begin
                cmd.run_start = 1'b1;
                state_next    = S_READ;
              end
            end
          endcase
        end
      end
      S_STATUS: begin
        if (st.out_free) begin
          cmd.emit_status = 1'b1;
          state_next      = S_HUNT;
        end
      end
      S_READ: begin
        // store read of run_idx is registered here; the data is valid in S_LOAD
        state_next = S_LOAD;
      end
      S_LOAD: begin
        if (st.out_free) begin
          cmd.run_load = 1'b1;
          state_next   = st.run_last ? S_HUNT : S_READ;
        end
      end
      default: begin
        state_next = S_HUNT;
      end
    endcase

    // Status result: emit and drop back to hunting, or hold the code in S_STATUS if the output is busy
    if (emit_req) begin
      cmd.clear_pos = 1'b1;
      if (st.out_free) begin
        cmd.emit_status = 1'b1;
        state_next      = S_HUNT;
      end else begin
        pend_next  = code;
        state_next = S_STATUS;
      end
    end
    cmd.status_code = code;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_HUNT;
      pend  <= rfr_pkg::ST_DATA;
    end else begin
      state <= state_next;
      pend  <= pend_next;
    end
  end

  `RFR_ASSERT_IMP(a_load_needs_slot, (cmd.emit_status || cmd.run_load), st.out_free, "result loaded into a busy output register")
  `RFR_ASSERT_IMP(a_run_only_good, cmd.run_start, (st.byte_eot && st.sum_ok && st.cmd_ok && !st.len_zero), "data run started for a frame that is not deliverable")
  `RFR_ASSERT_NXT(a_load_advances, (state == S_LOAD && st.out_free), (state == S_READ || state == S_HUNT), "data run did not advance after a load")

endmodule

// ===== rtl/rfr_datapath.sv =====
// Datapath of the RS485 frame receiver: configuration registers, header window, frame registers,
// checksum, idle counter, message store and output register. Depends on rfr_pkg.
module rfr_datapath #(
  parameter int unsigned MAX_BYTES = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [rfr_pkg::CFG_IW-1:0]    cfg_index,
  input  logic [rfr_pkg::CFG_DW-1:0]    cfg_data,
  input  rfr_pkg::rfr_item_t            item,
  input  rfr_pkg::rfr_cmd_t             cmd,
  output rfr_pkg::rfr_stat_t            st,
  output logic                          result_valid,
  input  logic                          result_ready,
  output rfr_pkg::rfr_result_t          result
);

  localparam logic [8:0] MaxLen = 9'(MAX_BYTES);

  logic [7:0]  gateway, broadcast, accept_cmd;
  logic [15:0] timeout;

  // Newest five bytes; the sixth header position is the incoming byte
  logic [7:0] window [5];

  logic [rfr_pkg::STORE_AW-1:0] pos, pos_inc, run_idx;
  logic [4:0]  frame_len;
  logic [7:0]  frame_dst, frame_src, frame_cmd;
  logic [7:0]  run_sum, rx_sum;
  logic [15:0] idle, idle_inc;
  logic [7:0]  store [rfr_pkg::STORE_DEPTH];
  logic [7:0]  rd_data;

  logic [7:0] b, h_dst, h_src, h_cmd, h_len;
  logic       len_ok;

  assign b     = item.rx_byte;
  assign h_dst = window[1];
  assign h_src = window[2];
  assign h_cmd = window[3];
  assign h_len = window[4];

  assign len_ok   = ({1'b0, h_len} < MaxLen) && (h_len < 8'(rfr_pkg::STORE_DEPTH));
  assign pos_inc  = pos + 5'd1;
  assign idle_inc = (idle == 16'hFFFF) ? idle : idle + 16'd1;

  always_comb begin
    st.is_tick      = item.kind;
    st.hdr_ok       = (window[0] == rfr_pkg::CH_SOH) && (b == rfr_pkg::CH_STX) &&
                      (h_dst != h_src) && (h_src != gateway) &&
                      ((h_dst == gateway) || (h_dst == broadcast)) && len_ok;
    st.hdr_len_zero = (h_len == 8'd0);
    st.pos_done     = (pos_inc == frame_len);
    st.byte_etx     = (b == rfr_pkg::CH_ETX);
    st.byte_eot     = (b == rfr_pkg::CH_EOT);
    st.sum_ok       = (rx_sum == run_sum);
    st.cmd_ok       = (frame_cmd == accept_cmd);
    st.len_zero     = (frame_len == 5'd0);
    st.timeout_hit  = (idle_inc > timeout);
    st.run_last     = (run_idx == frame_len - 5'd1);
    st.out_free     = !result_valid || result_ready;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gateway    <= 8'd0;
      broadcast  <= 8'd255;
      accept_cmd <= 8'd0;
      timeout    <= 16'd100;
    end else if (cfg_write) begin
      case (cfg_index)
        rfr_pkg::REG_GATEWAY:   gateway    <= cfg_data[7:0];
        rfr_pkg::REG_BROADCAST: broadcast  <= cfg_data[7:0];
        rfr_pkg::REG_COMMAND:   accept_cmd <= cfg_data[7:0];
        rfr_pkg::REG_TIMEOUT:   timeout    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Header window and frame registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 5; i++) begin
        window[i] <= 8'd0;
      end
      pos       <= '0;
      frame_len <= 5'd0;
      frame_dst <= 8'd0;
      frame_src <= 8'd0;
      frame_cmd <= 8'd0;
      run_sum   <= 8'd0;
      rx_sum    <= 8'd0;
      idle      <= 16'd0;
      run_idx   <= '0;
    end else begin
      if (cmd.shift_window) begin
        for (int i = 0; i < 4; i++) begin
          window[i] <= window[i+1];
        end
        window[4] <= b;
      end
      if (cmd.load_header) begin
        frame_dst <= h_dst;
        frame_src <= h_src;
        frame_cmd <= h_cmd;
        frame_len <= h_len[4:0];
        run_sum   <= h_dst + h_src + h_cmd + h_len;
        pos       <= '0;
      end
      if (cmd.store_byte) begin
        run_sum <= run_sum + b;
        pos     <= pos_inc;
      end
      if (cmd.clear_pos) begin
        pos <= '0;
      end
      if (cmd.take_sum) begin
        rx_sum <= b;
      end
      if (cmd.clear_idle) begin
        idle <= 16'd0;
      end else if (cmd.tick_idle) begin
        idle <= idle_inc;
      end
      if (cmd.run_start) begin
        run_idx <= '0;
      end else if (cmd.run_load) begin
        run_idx <= run_idx + 5'd1;
      end
    end
  end

  // Message store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.store_byte) begin
      store[pos] <= b;
    end
    rd_data <= store[run_idx];
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.emit_status || cmd.run_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_status) begin
      result.status       <= cmd.status_code;
      result.destination  <= frame_dst;
      result.source       <= frame_src;
      result.length       <= frame_len;
      result.index        <= 5'd0;
      result.payload_byte <= 8'd0;
      result.last         <= 1'b1;
    end else if (cmd.run_load) begin
      result.status       <= rfr_pkg::ST_DATA;
      result.destination  <= frame_dst;
      result.source       <= frame_src;
      result.length       <= frame_len;
      result.index        <= run_idx;
      result.payload_byte <= rd_data;
      result.last         <= st.run_last;
    end
  end

endmodule
